// ===== rtl/lbs_pkg.sv =====
// shared types and constants for the four-bone skinning engine
package lbs_pkg;

    localparam int BONE_COUNT_DEF = 80;
    localparam int COEFS          = 12;
    localparam int LANES          = 4;

    // blend divisors: weight scale, and weight scale times tangent scale
    localparam int DIV_POS = 255;
    localparam int DIV_TAN = 255 * 511;

    localparam int PP_W   = 64;
    localparam int TP_W   = 42;
    localparam int P_W    = 50;
    localparam int T_W    = 44;
    localparam int PW_W   = 59;
    localparam int TW_W   = 53;
    localparam int PACC_W = 61;
    localparam int TACC_W = 55;

    localparam int LANE_LAT = 4;
    localparam int DIV_LAT  = 5;
    localparam int PIPE_LAT = LANE_LAT + 1 + DIV_LAT;

    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [9:0]  tan_t;
    typedef logic signed [PW_W-1:0] pw_t;
    typedef logic signed [TW_W-1:0] tw_t;

    typedef struct packed {
        logic       en;
        logic [3:0] sel;
        logic [7:0] addr;
        q16_t       data;
    } pal_wr_t;

    typedef struct packed {
        logic last;
        logic bad;
    } meta_t;

endpackage

// ===== rtl/lbs_lane.sv =====
// one bone lane: palette copy, matrix transform and weighting
module lbs_lane #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF
) (
    input  logic             clk,
    input  logic             en,
    input  lbs_pkg::pal_wr_t wr,
    input  logic [7:0]       rd_idx,
    input  lbs_pkg::q16_t    pos [3],
    input  lbs_pkg::tan_t    tan [3],
    input  logic [7:0]       weight,
    output lbs_pkg::pw_t     pw [3],
    output lbs_pkg::tw_t     tw [3]
);

    localparam int IW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    logic          ok;
    logic [IW-1:0] rd_addr;

    lbs_pkg::q16_t coef_reg [lbs_pkg::COEFS];
    lbs_pkg::q16_t pos1_reg [3];
    lbs_pkg::tan_t tan1_reg [3];
    logic [7:0]    w1_reg;
    logic          ok1_reg;

    logic signed [lbs_pkg::PP_W-1:0] pp2_reg [9];
    logic signed [lbs_pkg::TP_W-1:0] tp2_reg [9];
    lbs_pkg::q16_t                   tr2_reg [3];
    logic [7:0]                      w2_reg;
    logic                            ok2_reg;

    logic signed [lbs_pkg::P_W-1:0] p3_reg [3];
    logic signed [lbs_pkg::T_W-1:0] t3_reg [3];
    logic [7:0]                     w3_reg;
    logic                           ok3_reg;

    lbs_pkg::pw_t pw4_reg [3];
    lbs_pkg::tw_t tw4_reg [3];

    assign ok      = {1'b0, rd_idx} < 9'(BONE_COUNT);
    assign rd_addr = ok ? rd_idx[IW-1:0] : '0;

    // one narrow memory per coefficient so all twelve read at one address
    for (genvar j = 0; j < lbs_pkg::COEFS; j++) begin : g_mem
        lbs_pkg::q16_t mem [BONE_COUNT];

        always_ff @(posedge clk)
        begin
            if (wr.en && wr.sel == 4'(j))
            begin
                mem[wr.addr[IW-1:0]] <= wr.data;
            end
            if (en)
            begin
                coef_reg[j] <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg <= pos;
            tan1_reg <= tan;
            w1_reg   <= weight;
            ok1_reg  <= ok;

            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pp2_reg[r*3+c] <= coef_reg[r*4+c] * pos1_reg[c];
                    tp2_reg[r*3+c] <= coef_reg[r*4+c] * tan1_reg[c];
                end
                tr2_reg[r] <= coef_reg[r*4+3];
            end
            w2_reg  <= w1_reg;
            ok2_reg <= ok1_reg;

            // arithmetic shift is floor division by 2^16
            for (int r = 0; r < 3; r++)
            begin
                p3_reg[r] <= lbs_pkg::P_W'(pp2_reg[r*3+0] >>> 16)
                           + lbs_pkg::P_W'(pp2_reg[r*3+1] >>> 16)
                           + lbs_pkg::P_W'(pp2_reg[r*3+2] >>> 16)
                           + lbs_pkg::P_W'(tr2_reg[r]);
                t3_reg[r] <= lbs_pkg::T_W'(tp2_reg[r*3+0])
                           + lbs_pkg::T_W'(tp2_reg[r*3+1])
                           + lbs_pkg::T_W'(tp2_reg[r*3+2]);
            end
            w3_reg  <= w2_reg;
            ok3_reg <= ok2_reg;

            for (int r = 0; r < 3; r++)
            begin
                if (ok3_reg)
                begin
                    pw4_reg[r] <= lbs_pkg::PW_W'(p3_reg[r])
                                * lbs_pkg::PW_W'($signed({1'b0, w3_reg}));
                    tw4_reg[r] <= lbs_pkg::TW_W'(t3_reg[r])
                                * lbs_pkg::TW_W'($signed({1'b0, w3_reg}));
                end
                else
                begin
                    pw4_reg[r] <= '0;
                    tw4_reg[r] <= '0;
                end
            end
        end
    end

    assign pw = pw4_reg;
    assign tw = tw4_reg;

endmodule

// ===== rtl/lbs_div.sv =====
// pipelined rounding division by a constant with 32-bit saturation
module lbs_div #(
    parameter int N = lbs_pkg::PACC_W,
    parameter int D = lbs_pkg::DIV_POS
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [N-1:0] x,
    output lbs_pkg::q16_t       y
);

    localparam int RW = $clog2(D) + 31;
    localparam logic [N:0] LIMIT = (N+1)'(D) << 31;

    // floor(m / D) equals (m * RECIP) >> SH for every m below 2^RW
    localparam int SH = RW + $clog2(D);
    localparam int ML = (RW + 1) / 2;
    localparam int MH = RW - ML;
    localparam int KH = RW + 1 - ML;
    localparam int SW = SH + 32;
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << SH) + 128'(D) - 128'd1) / 128'(D);
    localparam logic [ML-1:0] RECIP_LO = RECIP_FULL[ML-1:0];
    localparam logic [KH-1:0] RECIP_HI = RECIP_FULL[RW:ML];

    logic [N-1:0]  mag;
    logic [N:0]    m;
    logic [SW-1:0] sum;

    logic [RW-1:0]      m_reg;
    logic               neg_reg [4];
    logic               sat_reg [4];
    logic [2*ML-1:0]    pll_reg;
    logic [ML+KH-1:0]   plh_reg;
    logic [MH+ML-1:0]   phl_reg;
    logic [MH+KH-1:0]   phh_reg;
    logic [2*ML-1:0]    ll_reg;
    logic [ML+KH:0]     cross_reg;
    logic [MH+KH-1:0]   hh_reg;
    logic [30:0]        q_reg;
    lbs_pkg::q16_t      y_reg;

    assign mag = x[N-1] ? N'(-x) : N'(x);
    assign m   = (N+1)'(mag) + (N+1)'(D / 2);

    assign sum = SW'(ll_reg) + (SW'(cross_reg) << ML) + (SW'(hh_reg) << (2 * ML));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= x[N-1];
            sat_reg[0] <= m >= LIMIT;
            m_reg      <= (m >= LIMIT) ? '0 : m[RW-1:0];
            for (int i = 1; i < 4; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end

            // partial products of the reciprocal multiply
            pll_reg <= (2*ML)'(m_reg[ML-1:0]) * (2*ML)'(RECIP_LO);
            plh_reg <= (ML+KH)'(m_reg[ML-1:0]) * (ML+KH)'(RECIP_HI);
            phl_reg <= (MH+ML)'(m_reg[RW-1:ML]) * (MH+ML)'(RECIP_LO);
            phh_reg <= (MH+KH)'(m_reg[RW-1:ML]) * (MH+KH)'(RECIP_HI);

            ll_reg    <= pll_reg;
            cross_reg <= (ML+KH+1)'(plh_reg) + (ML+KH+1)'(phl_reg);
            hh_reg    <= phh_reg;

            q_reg <= sum[SH +: 31];

            if (sat_reg[3])
            begin
                y_reg <= neg_reg[3] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            else
            begin
                y_reg <= neg_reg[3] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
            end
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/four_bone_vertex_skinning.sv =====
// four-bone linear blend skinning engine, Q16.16 fixed point
//
// s_* channel takes one word per cycle. s_tuser picks the request: a coefficient
// write stores one 3x4 bone matrix entry and gives no result; a vertex request
// transforms position and tangent by four bones and blends them by byte weights.
// m_* channel carries one result word per vertex, in input order; m_tuser flags
// a bone index at or beyond the palette size, m_tlast copies s_tlast.
// A vertex passes from acceptance to m_tvalid through 4 lane stages (palette
// read, products, row sums, weighting), one lane merge stage, a 5-stage
// divider that forms the rounded blend quotient by reciprocal multiplication,
// and the output register. Throughput is one word per cycle while s_tready is
// high, in any mix of writes and vertices; a write is seen by a vertex accepted
// in the next cycle.
// Each lane keeps its own palette copy, twelve memories of BONE_COUNT entries.
// The palette is not cleared by reset and must be written before use.
// Reset empties the pipeline and output stages. When the receiver stalls, the
// pipeline fills the output register and a skid register, then freezes and
// drops s_tready until the skid register drains.
module four_bone_vertex_skinning #(
    parameter int BONE_COUNT = lbs_pkg::BONE_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bone_slot, matrix_row, matrix_col, coef_value, pos_x, pos_y, pos_z,
    // tangent_word, weight_word, index_word, zero pad
    input  logic [239:0] s_tdata,
    input  logic         s_tuser,   // req_type
    input  logic         s_tlast,   // last_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_tan_x, out_tan_y, out_tan_z
    output logic [191:0] m_tdata,
    output logic         m_tuser,   // bad_index
    output logic         m_tlast    // last_out
);

    localparam int L = lbs_pkg::PIPE_LAT;

    logic [6:0]  bone_slot;
    logic [1:0]  matrix_row;
    logic [1:0]  matrix_col;
    logic [31:0] weight_word;
    logic [31:0] index_word;
    logic [31:0] tangent_word;

    lbs_pkg::q16_t    pos [3];
    lbs_pkg::tan_t    tan [3];
    lbs_pkg::pal_wr_t wr;
    lbs_pkg::meta_t   meta_in;

    logic adv;
    logic accept;

    lbs_pkg::pw_t pw [lbs_pkg::LANES][3];
    lbs_pkg::tw_t tw [lbs_pkg::LANES][3];

    logic signed [lbs_pkg::PACC_W-1:0] pacc_reg [3];
    logic signed [lbs_pkg::TACC_W-1:0] tacc_reg [3];
    lbs_pkg::q16_t                     qpos [3];
    lbs_pkg::q16_t                     qtan [3];

    logic           vld_reg  [L];
    lbs_pkg::meta_t meta_reg [L];

    logic [191:0]   tail_data;
    logic [191:0]   out_data_reg;
    logic [191:0]   skid_data_reg;
    lbs_pkg::meta_t out_meta_reg;
    lbs_pkg::meta_t skid_meta_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;

    assign bone_slot    = s_tdata[6:0];
    assign matrix_row   = s_tdata[8:7];
    assign matrix_col   = s_tdata[10:9];
    assign pos[0]       = s_tdata[74:43];
    assign pos[1]       = s_tdata[106:75];
    assign pos[2]       = s_tdata[138:107];
    assign tangent_word = s_tdata[170:139];
    assign weight_word  = s_tdata[202:171];
    assign index_word   = s_tdata[234:203];

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    // -512 is folded onto -511 so the tangent scale is symmetric
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tan[i] = tangent_word[10*i +: 10];
            if (tan[i] == -10'sd512)
            begin
                tan[i] = -10'sd511;
            end
        end
    end

    always_comb
    begin
        wr.en   = accept && s_tuser == lbs_pkg::REQ_COEF
               && {2'b0, bone_slot} < 9'(BONE_COUNT) && matrix_row != 2'd3;
        wr.sel  = {matrix_row, matrix_col};
        wr.addr = 8'(bone_slot);
        wr.data = s_tdata[42:11];
    end

    always_comb
    begin
        meta_in.last = s_tlast;
        meta_in.bad  = 1'b0;
        for (int k = 0; k < lbs_pkg::LANES; k++)
        begin
            if ({1'b0, index_word[8*k +: 8]} >= 9'(BONE_COUNT))
            begin
                meta_in.bad = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < lbs_pkg::LANES; k++) begin : g_lane
        lbs_lane #(
            .BONE_COUNT(BONE_COUNT)
        ) u_lane (
            .clk    (clk),
            .en     (adv),
            .wr     (wr),
            .rd_idx (index_word[8*k +: 8]),
            .pos    (pos),
            .tan    (tan),
            .weight (weight_word[8*k +: 8]),
            .pw     (pw[k]),
            .tw     (tw[k])
        );
    end

    // lane merge
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pacc_reg[r] <= lbs_pkg::PACC_W'(pw[0][r]) + lbs_pkg::PACC_W'(pw[1][r])
                             + lbs_pkg::PACC_W'(pw[2][r]) + lbs_pkg::PACC_W'(pw[3][r]);
                tacc_reg[r] <= lbs_pkg::TACC_W'(tw[0][r]) + lbs_pkg::TACC_W'(tw[1][r])
                             + lbs_pkg::TACC_W'(tw[2][r]) + lbs_pkg::TACC_W'(tw[3][r]);
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_div
        lbs_div #(
            .N(lbs_pkg::PACC_W),
            .D(lbs_pkg::DIV_POS)
        ) u_div_pos (
            .clk (clk),
            .en  (adv),
            .x   (pacc_reg[r]),
            .y   (qpos[r])
        );

        lbs_div #(
            .N(lbs_pkg::TACC_W),
            .D(lbs_pkg::DIV_TAN)
        ) u_div_tan (
            .clk (clk),
            .en  (adv),
            .x   (tacc_reg[r]),
            .y   (qtan[r])
        );
    end

    // vertex valid tracks the data pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= accept && s_tuser == lbs_pkg::REQ_VERTEX;
            for (int i = 1; i < L; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= meta_in;
            for (int i = 1; i < L; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign tail_data = {qtan[2], qtan[1], qtan[0], qpos[2], qpos[1], qpos[0]};

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!(adv && vld_reg[L-1]))
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (adv && vld_reg[L-1])
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_meta_reg <= skid_meta_reg;
            end
            else if (adv && vld_reg[L-1])
            begin
                out_data_reg <= tail_data;
                out_meta_reg <= meta_reg[L-1];
            end
        end
        else if (adv && vld_reg[L-1])
        begin
            if (!out_valid_reg)
            begin
                out_data_reg <= tail_data;
                out_meta_reg <= meta_reg[L-1];
            end
            else
            begin
                skid_data_reg <= tail_data;
                skid_meta_reg <= meta_reg[L-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_meta_reg.bad;
    assign m_tlast  = out_meta_reg.last;

endmodule

// ===== dv/tb.sv =====
// testbench for the four-bone linear blend skinning engine
`timescale 1ns / 1ps

module tb;

    localparam int NBONES   = lbs_pkg::BONE_COUNT_DEF;
    localparam int WDOG_MAX = 5000;

    typedef struct packed {
        lbs_pkg::q16_t px, py, pz, tx, ty, tz;
        logic bad;
        logic last;
    } skin_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [239:0] s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    four_bone_vertex_skinning dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    lbs_pkg::q16_t palette [NBONES*lbs_pkg::COEFS];
    skin_res_t     skin_q[$];
    int            errors;
    int            idle_cycles;
    bit            send_gaps;
    bit            recv_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_q16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint round_div(longint x, longint d);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + d / 2) / d;
        return (x < 0) ? -m : m;
    endfunction

    function automatic lbs_pkg::q16_t clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic skin_res_t skin_vertex(lbs_pkg::q16_t px, lbs_pkg::q16_t py,
                                              lbs_pkg::q16_t pz,
                                              logic [31:0] tw, logic [31:0] ww,
                                              logic [31:0] iw, logic last);
        skin_res_t res;
        longint pos[3];
        longint tn[3];
        longint pacc[3];
        longint tacc[3];
        longint p, t, coef, w;
        int idx;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        res.bad = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            tn[i] = $signed(tw[10*i +: 10]);
            if (tn[i] < -511)
                tn[i] = -511;
            pacc[i] = 0;
            tacc[i] = 0;
        end
        for (int k = 0; k < lbs_pkg::LANES; k++)
        begin
            idx = iw[8*k +: 8];
            w = ww[8*k +: 8];
            if (idx >= NBONES)
            begin
                res.bad = 1'b1;
                continue;
            end
            for (int r = 0; r < 3; r++)
            begin
                p = palette[idx*lbs_pkg::COEFS + r*4 + 3];
                t = 0;
                for (int c = 0; c < 3; c++)
                begin
                    coef = palette[idx*lbs_pkg::COEFS + r*4 + c];
                    p += floor_q16(coef * pos[c]);
                    t += coef * tn[c];
                end
                pacc[r] += p * w;
                tacc[r] += t * w;
            end
        end
        res.px = clamp32(round_div(pacc[0], lbs_pkg::DIV_POS));
        res.py = clamp32(round_div(pacc[1], lbs_pkg::DIV_POS));
        res.pz = clamp32(round_div(pacc[2], lbs_pkg::DIV_POS));
        res.tx = clamp32(round_div(tacc[0], lbs_pkg::DIV_TAN));
        res.ty = clamp32(round_div(tacc[1], lbs_pkg::DIV_TAN));
        res.tz = clamp32(round_div(tacc[2], lbs_pkg::DIV_TAN));
        res.last = last;
        return res;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    // drive one word and wait for its acceptance
    task automatic send_word(logic req, logic [239:0] data, logic last);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            idle_burst();
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic finish_send();
        s_tvalid <= 1'b0;
    endtask

    task automatic write_coef(int bone, int row, int col, lbs_pkg::q16_t val);
        logic [239:0] d;
        d = '0;
        d[6:0]   = 7'(bone);
        d[8:7]   = 2'(row);
        d[10:9]  = 2'(col);
        d[42:11] = val;
        send_word(lbs_pkg::REQ_COEF, d, 1'b0);
        if (bone < NBONES && row < 3)
            palette[bone*lbs_pkg::COEFS + row*4 + col] = val;
    endtask

    task automatic skin(lbs_pkg::q16_t px, lbs_pkg::q16_t py, lbs_pkg::q16_t pz,
                        logic [31:0] tw, logic [31:0] ww, logic [31:0] iw,
                        logic last);
        logic [239:0] d;
        skin_res_t    exp_v;
        d = '0;
        d[10:0]    = 11'($urandom);
        d[42:11]   = $urandom;
        d[74:43]   = px;
        d[106:75]  = py;
        d[138:107] = pz;
        d[170:139] = tw;
        d[202:171] = ww;
        d[234:203] = iw;
        send_word(lbs_pkg::REQ_VERTEX, d, last);
        exp_v  = skin_vertex(px, py, pz, tw, ww, iw, last);
        skin_q = {skin_q, exp_v};
    endtask

    // pick a bone index; a few land past the palette
    function automatic logic [7:0] pick_index(int bad_pct);
        if ($urandom_range(0, 99) < bad_pct)
            return 8'($urandom_range(NBONES, 255));
        return 8'($urandom_range(0, NBONES - 1));
    endfunction

    function automatic lbs_pkg::q16_t rand_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
        endcase
    endfunction

    task automatic rand_vertex(int bad_pct);
        logic [31:0] iw;
        for (int k = 0; k < 4; k++)
            iw[8*k +: 8] = pick_index(bad_pct);
        skin(rand_q16(), rand_q16(), rand_q16(), $urandom, $urandom, iw,
             $urandom_range(0, 15) == 0);
    endtask

    task automatic drain();
        finish_send();
        while (skin_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_fill_palette();
        for (int b = 0; b < NBONES; b++)
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 4; c++)
                    write_coef(b, r, c, (r == c) ? 32'sh00010000 : 32'sh0);
    endtask

    task automatic test_directed();
        // identity bone 0, full weight
        skin(32'sh00012345, -32'sh00050000, 32'sh0, 32'h1ff7fdff, 32'h000000ff,
             32'h00000000, 1'b0);
        // extreme positions and tangent -512 clamp
        skin(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'h20080200, 32'hffffffff,
             32'h03020100, 1'b1);
        write_coef(1, 0, 0, 32'sh7fffffff);
        write_coef(1, 1, 3, 32'sh80000000);
        write_coef(1, 2, 1, 32'sh80000000);
        write_coef(2, 0, 3, 32'sh7fffffff);
        // ignored writes: bad slot, row three
        write_coef(NBONES, 0, 0, 32'sh12345678);
        write_coef(127, 2, 3, 32'sh12345678);
        write_coef(3, 3, 1, 32'sh12345678);
        skin(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff, 32'hffffffff,
             32'h01010101, 1'b0);
        skin(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'h0, 32'hffffffff,
             32'h02020101, 1'b0);
        // bad index with zero weight still flags
        skin(32'sh00010000, 32'sh00010000, 32'sh00010000, 32'h3ff, 32'h00ffffff,
             32'hff010203, 1'b1);
        skin(32'sh00010000, 32'sh0, 32'sh0, 32'h0, 32'h0, 32'h4f504f50, 1'b0);
        skin(-32'sh00008000, 32'sh0, 32'sh0, 32'hc0000000, 32'h00000001,
             32'h00000000, 1'b0);
        drain();
    endtask

    task automatic test_random_mix(int n);
        int b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                b = $urandom_range(0, 127);
                write_coef(b, $urandom_range(0, 3), $urandom_range(0, 3), rand_q16());
            end
            else
                rand_vertex(5);
        end
    endtask

    task automatic test_full_rate(int n);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        for (int i = 0; i < n; i++)
            rand_vertex(3);
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        skin_res_t exp_r;
        skin_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                   m_tdata[159:128], m_tdata[191:160], m_tuser, m_tlast};
            if (skin_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = skin_q.pop_front();
                if (got.px !== exp_r.px || got.py !== exp_r.py || got.pz !== exp_r.pz)
                begin
                    $display("%0t: position exp %h %h %h got %h %h %h", $time,
                             exp_r.px, exp_r.py, exp_r.pz, got.px, got.py, got.pz);
                    errors++;
                end
                if (got.tx !== exp_r.tx || got.ty !== exp_r.ty || got.tz !== exp_r.tz)
                begin
                    $display("%0t: tangent exp %h %h %h got %h %h %h", $time,
                             exp_r.tx, exp_r.ty, exp_r.tz, got.tx, got.ty, got.tz);
                    errors++;
                end
                if (got.bad !== exp_r.bad)
                begin
                    $display("%0t: bad_index exp %b got %b", $time, exp_r.bad, got.bad);
                    errors++;
                end
                if (got.last !== exp_r.last)
                begin
                    $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                idle_burst();
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("** four_bone_vertex_skinning: FAILED **");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = lbs_pkg::REQ_COEF;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_palette();
        test_directed();
        test_random_mix(300);
        // pause until everything is back
        drain();
        test_random_mix(100);
        test_full_rate(150);
        repeat (lbs_pkg::PIPE_LAT + 20) @(posedge clk);
        if (errors == 0)
            $display("** four_bone_vertex_skinning: PASSED **");
        else
            $display("** four_bone_vertex_skinning: FAILED **");
        $finish;
    end

endmodule
